>>> sv/dag_path_count_mod_prime_unit_macros.svh
// Assertion macros shared by the checker
`ifndef DAG_PATH_COUNT_MOD_PRIME_UNIT_MACROS_SVH
`define DAG_PATH_COUNT_MOD_PRIME_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define DPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define DPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> sv/dpc_pkg.sv
`default_nettype none
package dpc_pkg;
    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;
    localparam int NW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int CFGW = 11;
    localparam int PW = 30;
    localparam logic [PW-1:0] PRIME_MOD = 30'd1000000007;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef struct packed {
        logic          op;
        logic [NW-1:0] src;
        logic [NW-1:0] dst;
        logic          drop;
        logic [1:0]    status;
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LINK, S_INIT, S_TOP, S_RDEDGE, S_DEST, S_VIS,
        S_ADDV, S_POP, S_POPADD, S_ADV, S_ADV2, S_OUT
    } t_state;
endpackage
`default_nettype wire

>>> sv/dpc_if.sv
`default_nettype none
interface dpc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [9:0] edge_source;
    logic [9:0] edge_target;
    modport source(output valid, output opcode, output edge_source, output edge_target,
                   input ready);
    modport sink(input valid, input opcode, input edge_source, input edge_target,
                 output ready);
endinterface

interface dpc_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] path_count;
    logic [1:0]  status;
    modport source(output valid, output path_count, output status, input ready);
    modport sink(input valid, input path_count, input status, output ready);
endinterface

interface dpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/dpc_ram.sv
`default_nettype none
module dpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/dpc_front.sv
`default_nettype none
module dpc_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    dpc_in_if.sink                    in_ch,
    input  wire logic [dpc_pkg::NW:0] i_limit,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output dpc_pkg::t_cmd             o_cmd
);
    import dpc_pkg::*;
    logic [EW:0] r_count, n_count;
    logic [1:0]  r_err, n_err;
    logic        range_bad, full;

    assign in_ch.ready = !i_q_full;
    assign o_push = in_ch.valid && !i_q_full;
    assign range_bad = ({1'b0, in_ch.edge_source} >= i_limit) ||
                       ({1'b0, in_ch.edge_target} >= i_limit);
    assign full = (r_count == (EW+1)'(MAX_EDGES));

    // classify the item and track the running error code
    always_comb begin
        n_count = r_count;
        n_err = r_err;
        o_cmd.op = in_ch.opcode;
        o_cmd.src = in_ch.edge_source;
        o_cmd.dst = in_ch.edge_target;
        o_cmd.drop = 1'b0;
        o_cmd.status = r_err;
        if (in_ch.opcode == OP_START) begin
            n_count = '0;
            n_err = ST_OK;
        end else if (range_bad) begin
            o_cmd.drop = 1'b1;
            n_err = ST_RANGE;
        end else if (full) begin
            o_cmd.drop = 1'b1;
            if (r_err != ST_RANGE) n_err = ST_FULL;
        end else begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err <= ST_OK;
        end else if (o_push) begin
            r_count <= n_count;
            r_err <= n_err;
        end
    end
endmodule
`default_nettype wire

>>> sv/dpc_queue.sv
`default_nettype none
module dpc_queue (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  dpc_pkg::t_cmd i_cmd,
    output logic       o_full,
    output logic       o_empty,
    input  wire logic  i_pop,
    output dpc_pkg::t_cmd o_cmd
);
    import dpc_pkg::*;
    t_cmd       r_slot [4];
    logic [2:0] r_wp, r_rp;

    assign o_full = (r_wp[1:0] == r_rp[1:0]) && (r_wp[2] != r_rp[2]);
    assign o_empty = (r_wp == r_rp);
    assign o_cmd = r_slot[r_rp[1:0]];

    // hold payload in slots, advance pointers on transfer
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp[1:0]] <= i_cmd;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> sv/dpc_back.sv
`default_nettype none
module dpc_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [dpc_pkg::NW:0] i_limit,
    input  wire logic                 i_q_empty,
    input  dpc_pkg::t_cmd             i_cmd,
    output logic                      o_pop,
    dpc_out_if.source                 out_ch,
    output logic                      o_busy
);
    import dpc_pkg::*;
    localparam int FW = NW + EW + 1;

    t_state r_state, n_state;
    logic [NW-1:0] r_clr;
    logic [EW-1:0] r_ecnt;
    logic [NW:0]   r_sp;
    logic [NW-1:0] r_fnode, r_v;
    logic [EW-1:0] r_fedge;
    logic          r_fmore;
    logic [PW-1:0] r_acc;
    logic          r_ovalid;
    logic [PW-1:0] r_opc;
    logic [1:0]    r_ost;

    // RAM ports
    logic          hd_we;  logic [NW-1:0] hd_wa, hd_ra; logic [EW:0] hd_wd, hd_rd;
    logic          tl_we;  logic [NW-1:0] tl_wa, tl_ra; logic [EW-1:0] tl_wd, tl_rd;
    logic          nx_we;  logic [EW-1:0] nx_wa, nx_ra, nx_wd, nx_rd;
    logic          ds_we;  logic [EW-1:0] ds_wa, ds_ra; logic [NW-1:0] ds_wd, ds_rd;
    logic          vs_we;  logic [NW-1:0] vs_wa, vs_ra; logic vs_wd, vs_rd;
    logic          pt_we;  logic [NW-1:0] pt_wa, pt_ra; logic [PW-1:0] pt_wd, pt_rd;
    logic          sk_we;  logic [NW-1:0] sk_wa, sk_ra; logic [FW-1:0] sk_wd, sk_rd;

    // head word: used bit on top of edge index
    dpc_ram #(.WIDTH(EW+1), .DEPTH(MAX_NODES)) u_head (.i_clk, .i_we(hd_we),
        .i_waddr(hd_wa), .i_wdata(hd_wd), .i_raddr(hd_ra), .o_rdata(hd_rd));
    dpc_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_tail (.i_clk, .i_we(tl_we),
        .i_waddr(tl_wa), .i_wdata(tl_wd), .i_raddr(tl_ra), .o_rdata(tl_rd));
    dpc_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next (.i_clk, .i_we(nx_we),
        .i_waddr(nx_wa), .i_wdata(nx_wd), .i_raddr(nx_ra), .o_rdata(nx_rd));
    dpc_ram #(.WIDTH(NW), .DEPTH(MAX_EDGES)) u_dest (.i_clk, .i_we(ds_we),
        .i_waddr(ds_wa), .i_wdata(ds_wd), .i_raddr(ds_ra), .o_rdata(ds_rd));
    dpc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (.i_clk, .i_we(vs_we),
        .i_waddr(vs_wa), .i_wdata(vs_wd), .i_raddr(vs_ra), .o_rdata(vs_rd));
    dpc_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_path (.i_clk, .i_we(pt_we),
        .i_waddr(pt_wa), .i_wdata(pt_wd), .i_raddr(pt_ra), .o_rdata(pt_rd));
    // saved parent frames: node, edge, more
    dpc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_stack (.i_clk, .i_we(sk_we),
        .i_waddr(sk_wa), .i_wdata(sk_wd), .i_raddr(sk_ra), .o_rdata(sk_rd));

    logic [NW-1:0] last_node;
    logic [PW:0]   sum;
    logic [PW-1:0] sum_mod;
    logic          top_go, skip_v, sp_room;
    assign last_node = NW'(i_limit - 1'b1);
    assign sum = {1'b0, r_acc} + {1'b0, pt_rd};
    assign sum_mod = (sum >= {1'b0, PRIME_MOD}) ? PW'(sum - {1'b0, PRIME_MOD}) : sum[PW-1:0];
    assign o_busy = (r_state != S_IDLE) || !i_q_empty || r_ovalid;
    assign top_go = !r_ovalid || out_ch.ready;
    assign skip_v = ({1'b0, ds_rd} >= i_limit);
    assign sp_room = (r_sp < (NW+1)'(MAX_NODES));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr == NW'(MAX_NODES-1)) n_state = S_IDLE;
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.op == OP_START) n_state = S_INIT;
                    else if (!i_cmd.drop) n_state = S_LINK;
                end
            end
            S_LINK:   n_state = S_IDLE;
            S_INIT:   n_state = S_TOP;
            S_TOP:    n_state = S_RDEDGE;
            S_RDEDGE: n_state = r_fmore ? S_DEST : S_POP;
            S_DEST:   n_state = skip_v ? S_ADV : S_VIS;
            S_VIS: begin
                if (vs_rd) n_state = S_ADDV;
                else if (sp_room) n_state = S_TOP;
                else n_state = S_ADV;
            end
            S_ADDV:   n_state = S_ADV;
            S_POP:    n_state = (r_sp == (NW+1)'(1)) ? S_OUT : S_POPADD;
            S_POPADD: n_state = S_ADDV;
            S_ADV:    n_state = S_ADV2;
            S_ADV2:   n_state = S_RDEDGE;
            S_OUT:    if (top_go) n_state = S_CLEAR;
            default:  n_state = S_CLEAR;
        endcase
    end

    // memory control and pop
    always_comb begin
        hd_we = 1'b0; hd_wa = i_cmd.src; hd_wd = {1'b1, r_ecnt}; hd_ra = i_cmd.src;
        tl_we = 1'b0; tl_wa = i_cmd.src; tl_wd = r_ecnt; tl_ra = i_cmd.src;
        nx_we = 1'b0; nx_wa = tl_rd; nx_wd = r_ecnt; nx_ra = r_fedge;
        ds_we = 1'b0; ds_wa = r_ecnt; ds_wd = i_cmd.dst; ds_ra = r_fedge;
        vs_we = 1'b0; vs_wa = r_clr; vs_wd = 1'b0; vs_ra = ds_rd;
        pt_we = 1'b0; pt_wa = r_clr; pt_wd = '0; pt_ra = r_fnode;
        sk_we = 1'b0; sk_wa = NW'(r_sp - 1'b1); sk_wd = {r_fnode, r_fedge, r_fmore};
        sk_ra = NW'(r_sp - 2'd2);
        o_pop = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                hd_we = 1'b1; hd_wa = r_clr; hd_wd = '0;
                vs_we = 1'b1; pt_we = 1'b1;
            end
            S_IDLE: begin
                if (!i_q_empty && i_cmd.op == OP_EDGE && i_cmd.drop) o_pop = 1'b1;
            end
            S_LINK: begin
                // append the edge: link from the old tail or open the list
                o_pop = 1'b1;
                ds_we = 1'b1;
                tl_we = 1'b1;
                if (hd_rd[EW]) nx_we = 1'b1;
                else hd_we = 1'b1;
            end
            S_INIT: begin
                hd_ra = '0;
                vs_we = 1'b1; vs_wa = '0; vs_wd = 1'b1;
                pt_we = 1'b1; pt_wa = last_node; pt_wd = PW'(1);
            end
            S_DEST: begin
                vs_ra = ds_rd; pt_ra = ds_rd;
            end
            S_VIS: begin
                hd_ra = r_v;
                pt_ra = r_fnode;
                if (!vs_rd) begin
                    vs_we = 1'b1; vs_wa = r_v; vs_wd = 1'b1;
                    sk_we = sp_room;
                end
            end
            S_ADDV: begin
                pt_we = 1'b1; pt_wa = r_fnode; pt_wd = sum_mod;
            end
            S_POPADD: pt_ra = sk_rd[FW-1:EW+1];
            S_ADV: begin
                tl_ra = r_fnode; nx_ra = r_fedge;
            end
            S_OUT: begin
                pt_ra = '0;
                o_pop = top_go;
            end
            default: ;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_INIT: begin
                r_fnode <= '0;
                r_sp <= (NW+1)'(1);
            end
            S_TOP: begin
                r_fedge <= hd_rd[EW-1:0];
                r_fmore <= hd_rd[EW];
            end
            S_DEST: r_v <= ds_rd;
            S_VIS: begin
                if (vs_rd) r_acc <= pt_rd;
                else if (sp_room) begin
                    r_fnode <= r_v;
                    r_sp <= r_sp + 1'b1;
                end
            end
            S_POP: r_sp <= r_sp - 1'b1;
            S_POPADD: begin
                r_fnode <= sk_rd[FW-1:EW+1];
                r_fedge <= sk_rd[EW:1];
                r_fmore <= sk_rd[0];
                r_acc <= pt_rd;
            end
            S_ADV2: begin
                if (r_fedge == tl_rd) r_fmore <= 1'b0;
                else r_fedge <= nx_rd;
            end
            S_OUT: begin
                if (top_go) begin
                    r_opc <= pt_rd;
                    r_ost <= i_cmd.status;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_ecnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == S_LINK) r_ecnt <= r_ecnt + 1'b1;
            else if (r_state == S_OUT && top_go) r_ecnt <= '0;
            if (r_state == S_OUT && top_go) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.path_count = r_opc;
    assign out_ch.status = r_ost;
endmodule
`default_nettype wire

>>> sv/dag_path_count_mod_prime_unit.sv
//  channel  | dir | transfer when       | payload
//  in_ch    | in  | valid && ready      | opcode, edge_source, edge_target
//  out_ch   | out | valid && ready      | path_count, status
//  cfg_ch   | in  | valid && ready      | nodes_in_use
// Edge items: S_IDLE and S_LINK in the back end, S_IDLE alone when dropped; queued
// four deep. A start item walks the graph with one read port per RAM: S_INIT, S_TOP
// open it, then per edge S_RDEDGE, S_DEST, then S_VIS, S_ADDV to a visited node, a
// descent to a new node, S_ADV to a skipped one. After reset and after each result a
// clearing pass over all 1024 nodes runs. Reset is synchronous, active low; either
// side may stall freely; the node count is taken only while the block is idle.
`default_nettype none
module dag_path_count_mod_prime_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpc_in_if.sink    in_ch,
    dpc_out_if.source out_ch,
    dpc_cfg_if.sink   cfg_ch
);
    import dpc_pkg::*;
    logic [CFGW-1:0] r_nodes;
    logic [NW:0]     limit;
    logic            q_full, q_empty, push, pop, busy;
    t_cmd            f_cmd, b_cmd;

    assign cfg_ch.ready = !busy;
    // hold the node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_nodes <= CFGW'(1);
        else if (cfg_ch.valid && cfg_ch.ready) r_nodes <= cfg_ch.data;
    end
    assign limit = (r_nodes == '0) ? (NW+1)'(1) :
                   (r_nodes > CFGW'(MAX_NODES)) ? (NW+1)'(MAX_NODES) : (NW+1)'(r_nodes);

    dpc_front u_front (.i_clk, .i_rst_n, .in_ch, .i_limit(limit), .i_q_full(q_full),
        .o_push(push), .o_cmd(f_cmd));
    dpc_queue u_queue (.i_clk, .i_rst_n, .i_push(push), .i_cmd(f_cmd), .o_full(q_full),
        .o_empty(q_empty), .i_pop(pop), .o_cmd(b_cmd));
    dpc_back u_back (.i_clk, .i_rst_n, .i_limit(limit), .i_q_empty(q_empty), .i_cmd(b_cmd),
        .o_pop(pop), .out_ch, .o_busy(busy));
endmodule
`default_nettype wire

>>> sv/dpc_checker.sv
`default_nettype none
`include "dag_path_count_mod_prime_unit_macros.svh"
module dpc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [29:0] out_path_count,
    input wire logic [1:0]  out_status
);
    `DPC_ASSERT_IMP(a_count_range, i_clk, i_rst_n, out_valid, out_path_count < 30'd1000000007, "count not reduced")
    `DPC_ASSERT_IMP(a_status_code, i_clk, i_rst_n, out_valid, out_status != 2'd3, "bad status")
    `DPC_ASSERT_NXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_path_count), "result dropped")
endmodule

bind dag_path_count_mod_prime_unit dpc_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_path_count(out_ch.path_count), .out_status(out_ch.status));
`default_nettype wire
